// ----- design/fr_pkg.sv -----
// ----------------------------------------------------------------------------
// fr_pkg
// Shared types and constants for the fraction reducer: request and result
// payloads, status codes and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package fr_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DATA_WIDTH);
  localparam int SHIFT_W    = $clog2(DATA_WIDTH);

  localparam logic [DATA_WIDTH-1:0] SIGN_BIT = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic [DATA_WIDTH-1:0] MAX_POS  = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] ONE      = {{(DATA_WIDTH-1){1'b0}}, 1'b1};

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_ZERO_DEN  = 2'd1,
    STATUS_SATURATED = 2'd2
  } fr_status_e;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] numerator_in;
    logic signed [DATA_WIDTH-1:0] denominator_in;
  } fr_req_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] numerator_out;
    logic        [DATA_WIDTH-2:0] denominator_out;
    fr_status_e                   status;
  } fr_res_t;

  typedef struct packed {
    logic load;
    logic gcd_step;
    logic div_init;
    logic div_step;
    logic finish;
  } fr_cmd_t;

  typedef struct packed {
    logic gcd_done;
  } fr_sts_t;

endpackage

// ----- design/fr_ctrl.sv -----
// ----------------------------------------------------------------------------
// fr_ctrl
// Sequencer for the fraction reducer: load, binary gcd loop, bit-serial
// division of both magnitudes, result capture and the done strobe.
// ----------------------------------------------------------------------------
module fr_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  fr_pkg::fr_sts_t sts_i,
  output fr_pkg::fr_cmd_t cmd_o,
  output logic            busy_o,
  output logic            done_o
);
  import fr_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GCD,
    ST_DIV,
    ST_FIN
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;
  logic             done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            state_q <= ST_GCD;
          end
        end
        ST_GCD: begin
          if (sts_i.gcd_done) begin
            state_q <= ST_DIV;
            cnt_q   <= '0;
          end
        end
        ST_DIV: begin
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == CNT_W'(DATA_WIDTH - 1)) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          state_q <= ST_IDLE;
          done_q  <= 1'b1;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = (state_q == ST_IDLE) && start_i;
    cmd_o.gcd_step = (state_q == ST_GCD) && !sts_i.gcd_done;
    cmd_o.div_init = (state_q == ST_GCD) && sts_i.gcd_done;
    cmd_o.div_step = (state_q == ST_DIV);
    cmd_o.finish   = (state_q == ST_FIN);
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;

  a_done_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("done strobe while busy");

  a_start_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("request accepted but block not busy");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("done strobe longer than one cycle");

endmodule

// ----- design/fr_dp.sv -----
// ----------------------------------------------------------------------------
// fr_dp
// Datapath for the fraction reducer: sign and magnitude split, binary gcd
// registers, two restoring dividers sharing one divisor, and result
// formatting with saturation.
// ----------------------------------------------------------------------------
module fr_dp (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  fr_pkg::fr_cmd_t cmd_i,
  input  fr_pkg::fr_req_t req_i,
  output fr_pkg::fr_sts_t sts_o,
  output fr_pkg::fr_res_t res_o
);
  import fr_pkg::*;

  logic [DATA_WIDTH-1:0] nm_q, dm_q;
  logic [DATA_WIDTH-1:0] a_q, b_q;
  logic [SHIFT_W-1:0]    k_q;
  logic [DATA_WIDTH-1:0] g_q;
  logic [DATA_WIDTH-1:0] nq_q, dq_q;
  logic [DATA_WIDTH-1:0] nr_q, dr_q;
  logic                  n_neg_q, d_neg_q, zero_q;
  fr_res_t               res_q;

  // load stage
  logic [DATA_WIDTH-1:0] n_in, d_in, d_eff;
  logic                  d_zero;

  // divider step
  logic [DATA_WIDTH:0]   nt, dt;
  logic                  n_ge, d_ge;

  // result formatting
  logic       sat_n, sat_d, res_neg;
  fr_res_t    res_d;

  assign n_in   = req_i.numerator_in;
  assign d_in   = req_i.denominator_in;
  assign d_zero = (d_in == '0);
  assign d_eff  = d_zero ? ONE : d_in;

  assign nt   = {nr_q, nq_q[DATA_WIDTH-1]};
  assign dt   = {dr_q, dq_q[DATA_WIDTH-1]};
  assign n_ge = (nt >= {1'b0, g_q});
  assign d_ge = (dt >= {1'b0, g_q});

  assign sts_o.gcd_done = (a_q == '0) || (b_q == '0);

  always_comb begin
    sat_n   = n_neg_q && d_neg_q && (nq_q == SIGN_BIT);
    sat_d   = d_neg_q && (dq_q == SIGN_BIT);
    res_neg = (n_neg_q != d_neg_q) && (nq_q != '0);
    if (sat_n) begin
      res_d.numerator_out = MAX_POS;
    end else if (res_neg) begin
      res_d.numerator_out = ~nq_q + ONE;
    end else begin
      res_d.numerator_out = nq_q;
    end
    res_d.denominator_out = sat_d ? MAX_POS[DATA_WIDTH-2:0] : dq_q[DATA_WIDTH-2:0];
    if (sat_n || sat_d) begin
      res_d.status = STATUS_SATURATED;
    end else if (zero_q) begin
      res_d.status = STATUS_ZERO_DEN;
    end else begin
      res_d.status = STATUS_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      zero_q  <= d_zero;
      n_neg_q <= n_in[DATA_WIDTH-1];
      d_neg_q <= d_eff[DATA_WIDTH-1];
      nm_q    <= n_in[DATA_WIDTH-1] ? (~n_in + ONE) : n_in;
      dm_q    <= d_eff[DATA_WIDTH-1] ? (~d_eff + ONE) : d_eff;
      a_q     <= n_in[DATA_WIDTH-1] ? (~n_in + ONE) : n_in;
      b_q     <= d_eff[DATA_WIDTH-1] ? (~d_eff + ONE) : d_eff;
      k_q     <= '0;
    end
    if (cmd_i.gcd_step) begin
      priority if (!a_q[0] && !b_q[0]) begin
        a_q <= a_q >> 1;
        b_q <= b_q >> 1;
        k_q <= k_q + SHIFT_W'(1);
      end else if (!a_q[0]) begin
        a_q <= a_q >> 1;
      end else if (!b_q[0]) begin
        b_q <= b_q >> 1;
      end else if (a_q >= b_q) begin
        a_q <= a_q - b_q;
      end else begin
        b_q <= b_q - a_q;
      end
    end
    if (cmd_i.div_init) begin
      // the common power of two goes back in here
      g_q  <= (a_q | b_q) << k_q;
      nq_q <= nm_q;
      dq_q <= dm_q;
      nr_q <= '0;
      dr_q <= '0;
    end
    if (cmd_i.div_step) begin
      nq_q <= {nq_q[DATA_WIDTH-2:0], n_ge};
      dq_q <= {dq_q[DATA_WIDTH-2:0], d_ge};
      nr_q <= n_ge ? DATA_WIDTH'(nt - {1'b0, g_q}) : nt[DATA_WIDTH-1:0];
      dr_q <= d_ge ? DATA_WIDTH'(dt - {1'b0, g_q}) : dt[DATA_WIDTH-1:0];
    end
    if (cmd_i.finish) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

  a_gcd_operands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.gcd_step |-> (a_q != '0) && (b_q != '0))
    else $error("gcd step with a zero operand");

  a_divisor_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (g_q != '0))
    else $error("division by zero gcd");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (nr_q < g_q) && (dr_q < g_q))
    else $error("partial remainder not below divisor");

endmodule

// ----- design/fraction_reducer_top.sv -----
// ----------------------------------------------------------------------------
// fraction_reducer_top
// Reduces a signed fraction to lowest terms with a positive denominator.
// ----------------------------------------------------------------------------
// from the accepting edge the block runs the binary gcd steps (one shift or
// subtract each, possibly none), then the gcd exit, the bit-serial divide
// steps, the result capture and the done cycle.
// a new request is taken only while idle; busy_o drops in the done cycle.
// the result shows on res_o with done_o high for one cycle; no stall possible.
// reset clears the sequencer only; res_o is undefined until the first done.
module fraction_reducer_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  fr_pkg::fr_req_t req_i,
  output logic            busy_o,
  output logic            done_o,
  output fr_pkg::fr_res_t res_o
);
  import fr_pkg::*;

  fr_cmd_t cmd;
  fr_sts_t sts;

  fr_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy_o),
    .done_o (done_o)
  );

  fr_dp u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd),
    .req_i (req_i),
    .sts_o (sts),
    .res_o (res_o)
  );

endmodule
